[rtl/core/ucdp_pkg.sv]
// Shared types and constants for the configuration descriptor parser.
package ucdp_pkg;

	localparam logic [7:0] TYPE_INTERFACE = 8'd4;
	localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;
	localparam logic [7:0] IF_MIN_LEN     = 8'd8;
	localparam logic [7:0] EP_MIN_LEN     = 8'd6;
	localparam logic [1:0] ATTR_TYPE_MASK = 2'h3;
	localparam logic [7:0] DIR_IN_BIT     = 8'h80;
	localparam logic [3:0] EP_NUM_MASK    = 4'hF;

	// one classified byte, front to back
	typedef struct packed {
		logic       lane_we;
		logic [1:0] lane;
		logic [7:0] data;
		logic       commit_if;
		logic       commit_ep;
		logic       last;
	} op_t;

	typedef struct packed {
		logic       interface_seen;
		logic [7:0] interface_number;
		logic [7:0] interface_class;
		logic [7:0] interface_subclass;
		logic [7:0] interface_protocol;
		logic       in_seen;
		logic [3:0] in_endpoint;
		logic [15:0] in_max_packet;
		logic       out_seen;
		logic [3:0] out_endpoint;
	} result_t;

endpackage

[rtl/core/ucdp_front.sv]
// Front end: walks the length/type chain and classifies each byte.
module ucdp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      data_byte,
	input  logic            last_byte,
	output ucdp_pkg::op_t   op
);
	import ucdp_pkg::*;

	logic [7:0] pos_q;
	logic [7:0] len_q;
	logic [7:0] type_q;
	logic       halted_q;
	logic [7:0] eff_type;
	logic       at_end;

	always_comb begin
		eff_type = (pos_q == 8'd1) ? data_byte : type_q;
		at_end   = ({1'b0, pos_q} + 9'd1) >= {1'b0, len_q};
		op       = '0;
		op.data  = data_byte;
		op.last  = last_byte;
		if (!halted_q && pos_q != 8'd0) begin
			if (pos_q != 8'd1) begin
				if (type_q == TYPE_INTERFACE) begin
					if (pos_q == 8'd2) begin
						op.lane_we = 1'b1;
						op.lane    = 2'd0;
					end else if (pos_q >= 8'd5 && pos_q <= 8'd7) begin
						op.lane_we = 1'b1;
						op.lane    = 2'(pos_q - 8'd4);
					end
				end else if (type_q == TYPE_ENDPOINT) begin
					if (pos_q >= 8'd2 && pos_q <= 8'd5) begin
						op.lane_we = 1'b1;
						op.lane    = 2'(pos_q - 8'd2);
					end
				end
			end
			if (at_end) begin
				op.commit_if = (eff_type == TYPE_INTERFACE) && (len_q >= IF_MIN_LEN);
				op.commit_ep = (eff_type == TYPE_ENDPOINT) && (len_q >= EP_MIN_LEN);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			len_q    <= '0;
			type_q   <= '0;
			halted_q <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				pos_q    <= '0;
				len_q    <= '0;
				type_q   <= '0;
				halted_q <= 1'b0;
			end else if (!halted_q) begin
				if (pos_q == 8'd0) begin
					if (data_byte == 8'd0) begin
						halted_q <= 1'b1;
					end else begin
						len_q  <= data_byte;
						type_q <= '0;
						pos_q  <= (data_byte != 8'd1) ? 8'd1 : 8'd0;
					end
				end else begin
					type_q <= eff_type;
					pos_q  <= at_end ? 8'd0 : pos_q + 8'd1;
				end
			end
		end
	end

endmodule

[rtl/core/ucdp_queue.sv]
// Small FIFO of classified bytes between front and back.
module ucdp_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ucdp_pkg::op_t   push_op,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output ucdp_pkg::op_t   head
);
	import ucdp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

[rtl/core/ucdp_back.sv]
// Back end: gathers field bytes, commits descriptors, registers the result.
module ucdp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        wanted_type,
	input  logic              op_valid,
	input  ucdp_pkg::op_t     op,
	output logic              op_pop,
	output logic              res_valid,
	input  logic              res_ready,
	output ucdp_pkg::result_t res
);
	import ucdp_pkg::*;

	logic [31:0] pend_q;
	result_t     comm_q;
	result_t     res_q;
	logic        res_valid_q;
	logic [31:0] pend_nx;
	result_t     comm_nx;

	assign op_pop    = op_valid && !(op.last && res_valid_q && !res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		pend_nx = pend_q;
		if (op.lane_we) begin
			case (op.lane)
				2'd0: pend_nx[7:0]   = op.data;
				2'd1: pend_nx[15:8]  = op.data;
				2'd2: pend_nx[23:16] = op.data;
				2'd3: pend_nx[31:24] = op.data;
				default: pend_nx = pend_q;
			endcase
		end
		comm_nx = comm_q;
		if (op.commit_if) begin
			comm_nx.interface_seen     = 1'b1;
			comm_nx.interface_number   = pend_nx[7:0];
			comm_nx.interface_class    = pend_nx[15:8];
			comm_nx.interface_subclass = pend_nx[23:16];
			comm_nx.interface_protocol = pend_nx[31:24];
		end else if (op.commit_ep && ((pend_nx[9:8] & ATTR_TYPE_MASK) == wanted_type)) begin
			if ((pend_nx[7:0] & DIR_IN_BIT) != 8'd0) begin
				comm_nx.in_seen       = 1'b1;
				comm_nx.in_endpoint   = pend_nx[3:0] & EP_NUM_MASK;
				comm_nx.in_max_packet = pend_nx[31:16];
			end else begin
				comm_nx.out_seen     = 1'b1;
				comm_nx.out_endpoint = pend_nx[3:0] & EP_NUM_MASK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop && op.last) begin
			res_q <= comm_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			comm_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (op_pop) begin
				if (op.last) begin
					pend_q <= '0;
					comm_q <= '0;
				end else begin
					pend_q <= pend_nx;
					comm_q <= comm_nx;
				end
			end
			if (op_pop && op.last) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/usb_config_descriptor_parser.sv]
// Top level of the USB configuration descriptor parser.
// Usage:
//   Input channel (in_valid/in_ready): one descriptor byte per beat, with
//   last_byte set on the final byte of the block's total length.
//   Result channel (out_valid/out_ready): one beat per block, issued for the
//   byte flagged last_byte, carrying the captured interface, IN and OUT
//   endpoint fields with a seen flag per group (fields are zero when unseen).
//   Config channel (cfg_valid/cfg_ready): writes wanted_endpoint_type; always
//   ready, write only while no block is in flight.
// Timing: one byte per cycle while in_ready is high. A byte is classified by the
//   front, queued, and applied by the back when it reaches the queue head;
//   out_valid is registered and rises when the back pops the last byte.
// Stall: a stalled result holds in the output register; the back keeps
//   applying bytes until the next last byte reaches it, then the
//   QUEUE_DEPTH-entry queue fills and in_ready drops.
// Reset: clears the walk state, committed fields and queue;
//   wanted_endpoint_type returns to 3 (interrupt).
module usb_config_descriptor_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  wanted_endpoint_type,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        interface_seen,
	output logic [7:0]  interface_number,
	output logic [7:0]  interface_class,
	output logic [7:0]  interface_subclass,
	output logic [7:0]  interface_protocol,
	output logic        in_seen,
	output logic [3:0]  in_endpoint,
	output logic [15:0] in_max_packet,
	output logic        out_seen,
	output logic [3:0]  out_endpoint
);
	import ucdp_pkg::*;

	logic [1:0] wanted_q;
	logic       take;
	logic       q_full;
	logic       q_empty;
	logic       q_pop;
	op_t        front_op;
	op_t        head_op;
	result_t    res;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign take      = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= 2'd3;
		end else if (cfg_valid) begin
			wanted_q <= wanted_endpoint_type;
		end
	end

	ucdp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.op        (front_op)
	);

	ucdp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (take),
		.push_op (front_op),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head    (head_op)
	);

	ucdp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wanted_type (wanted_q),
		.op_valid    (!q_empty),
		.op          (head_op),
		.op_pop      (q_pop),
		.res_valid   (out_valid),
		.res_ready   (out_ready),
		.res         (res)
	);

	assign interface_seen     = res.interface_seen;
	assign interface_number   = res.interface_number;
	assign interface_class    = res.interface_class;
	assign interface_subclass = res.interface_subclass;
	assign interface_protocol = res.interface_protocol;
	assign in_seen            = res.in_seen;
	assign in_endpoint        = res.in_endpoint;
	assign in_max_packet      = res.in_max_packet;
	assign out_seen           = res.out_seen;
	assign out_endpoint       = res.out_endpoint;

endmodule

[dv/usb_config_descriptor_parser_tb.sv]
// Testbench for the USB configuration descriptor parser: directed and random blocks, scoreboarded.
module usb_config_descriptor_parser_tb;
	import ucdp_pkg::*;

	localparam logic [1:0] XFER_CONTROL   = 2'd0;
	localparam logic [1:0] XFER_ISOCH     = 2'd1;
	localparam logic [1:0] XFER_BULK      = 2'd2;
	localparam logic [1:0] XFER_INTERRUPT = 2'd3;
	localparam logic [7:0] TYPE_CONFIGURATION = 8'h02;
	localparam logic [7:0] TYPE_HID           = 8'h21;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  wanted_endpoint_type;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic        interface_seen;
	logic [7:0]  interface_number;
	logic [7:0]  interface_class;
	logic [7:0]  interface_subclass;
	logic [7:0]  interface_protocol;
	logic        in_seen;
	logic [3:0]  in_endpoint;
	logic [15:0] in_max_packet;
	logic        out_seen;
	logic [3:0]  out_endpoint;

	// walker state mirrored from the block
	logic [1:0]  want_xfer = XFER_INTERRUPT;
	logic [7:0]  desc_pos = '0;
	logic [7:0]  walk_len = '0;
	logic [7:0]  walk_kind = '0;
	logic        walk_halted = 1'b0;
	logic [31:0] field_lanes = '0;
	result_t     captured = '0;

	result_t     expected_reports[$];
	result_t     next_report;
	logic [7:0]  block_bytes[$];

	int mismatches = 0;
	int reports_checked = 0;
	int bytes_sent = 0;
	int blocks_sent = 0;
	int hold_span = 0;
	bit sender_idles = 1'b1;
	bit recv_idles = 1'b1;

	usb_config_descriptor_parser DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.wanted_endpoint_type(wanted_endpoint_type),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.data_byte          (data_byte),
		.last_byte          (last_byte),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.interface_seen     (interface_seen),
		.interface_number   (interface_number),
		.interface_class    (interface_class),
		.interface_subclass (interface_subclass),
		.interface_protocol (interface_protocol),
		.in_seen            (in_seen),
		.in_endpoint        (in_endpoint),
		.in_max_packet      (in_max_packet),
		.out_seen           (out_seen),
		.out_endpoint       (out_endpoint)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

	// advance the descriptor walk by one accepted byte; a last byte closes the block
	function automatic void walk_byte(input logic [7:0] b, input logic last);
		int lane;
		logic [7:0] addr;
		logic [7:0] attr;
		lane = -1;
		if (!walk_halted) begin
			if (desc_pos == 8'd0) begin
				if (b == 8'd0) begin
					walk_halted = 1'b1;
				end else begin
					walk_len = b;
					walk_kind = 8'd0;
					field_lanes = '0;
					if (b != 8'd1)
						desc_pos = 8'd1;
				end
			end else begin
				if (desc_pos == 8'd1) begin
					walk_kind = b;
				end else if (walk_kind == TYPE_INTERFACE) begin
					if (desc_pos == 8'd2)
						lane = 0;
					else if (desc_pos >= 8'd5 && desc_pos <= 8'd7)
						lane = int'(desc_pos) - 4;
				end else if (walk_kind == TYPE_ENDPOINT) begin
					if (desc_pos >= 8'd2 && desc_pos <= 8'd5)
						lane = int'(desc_pos) - 2;
				end
				if (lane >= 0)
					field_lanes[lane*8 +: 8] = b;
				if (int'(desc_pos) + 1 >= int'(walk_len)) begin
					addr = field_lanes[7:0];
					attr = field_lanes[15:8];
					if (walk_kind == TYPE_INTERFACE && walk_len >= IF_MIN_LEN) begin
						captured.interface_seen = 1'b1;
						captured.interface_number = field_lanes[7:0];
						captured.interface_class = field_lanes[15:8];
						captured.interface_subclass = field_lanes[23:16];
						captured.interface_protocol = field_lanes[31:24];
					end else if (walk_kind == TYPE_ENDPOINT && walk_len >= EP_MIN_LEN &&
							(attr[1:0] & ATTR_TYPE_MASK) == want_xfer) begin
						if ((addr & DIR_IN_BIT) != 8'd0) begin
							captured.in_seen = 1'b1;
							captured.in_endpoint = addr[3:0] & EP_NUM_MASK;
							captured.in_max_packet = field_lanes[31:16];
						end else begin
							captured.out_seen = 1'b1;
							captured.out_endpoint = addr[3:0] & EP_NUM_MASK;
						end
					end
					desc_pos = 8'd0;
				end else begin
					desc_pos = desc_pos + 8'd1;
				end
			end
		end
		if (last) begin
			expected_reports.push_back(captured);
			captured = '0;
			desc_pos = '0;
			walk_len = '0;
			walk_kind = '0;
			walk_halted = 1'b0;
			field_lanes = '0;
			blocks_sent++;
		end
	endfunction

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0h actual %0h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: report beat with none pending");
			end else begin
				next_report = expected_reports.pop_front();
				compare_field("interface_seen", 16'(next_report.interface_seen),
					16'(interface_seen));
				compare_field("interface_number", 16'(next_report.interface_number),
					16'(interface_number));
				compare_field("interface_class", 16'(next_report.interface_class),
					16'(interface_class));
				compare_field("interface_subclass", 16'(next_report.interface_subclass),
					16'(interface_subclass));
				compare_field("interface_protocol", 16'(next_report.interface_protocol),
					16'(interface_protocol));
				compare_field("in_seen", 16'(next_report.in_seen), 16'(in_seen));
				compare_field("in_endpoint", 16'(next_report.in_endpoint),
					16'(in_endpoint));
				compare_field("in_max_packet", next_report.in_max_packet, in_max_packet);
				compare_field("out_seen", 16'(next_report.out_seen), 16'(out_seen));
				compare_field("out_endpoint", 16'(next_report.out_endpoint),
					16'(out_endpoint));
				reports_checked++;
			end
		end
	end

	// result sink: random stalls, plus a counted hold-off on request
	initial begin
		int span;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_span != 0) begin
				span = hold_span;
				hold_span = 0;
				out_ready <= 1'b0;
				repeat (span) @(posedge clk);
			end
			out_ready <= !recv_idles || $urandom_range(99) >= 11;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (sender_idles && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
		walk_byte(b, last);
	endtask

	task automatic send_block();
		for (int i = 0; i < block_bytes.size(); i++)
			send_byte(block_bytes[i], i == block_bytes.size() - 1);
	endtask

	// drop valid, wait out every pending report, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_endpoint_type(input logic [1:0] xfer);
		settle();
		cfg_valid <= 1'b1;
		wanted_endpoint_type <= xfer;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		want_xfer = xfer;
	endtask

	task automatic push_descriptor();
		int pick;
		int len;
		logic [7:0] kind;
		logic [7:0] addr;
		logic [7:0] attr;
		logic [15:0] mp;
		pick = $urandom_range(99);
		addr = 8'($urandom_range(255));
		attr = 8'($urandom_range(255));
		if ($urandom_range(1) != 0)
			attr[1:0] = want_xfer;
		mp = ($urandom_range(1) != 0) ? 16'($urandom_range(1023)) : 16'($urandom_range(65535));
		if (pick < 35) begin
			kind = TYPE_INTERFACE;
			len = ($urandom_range(4) != 0) ? 9 : $urandom_range(2, 12);
		end else if (pick < 80) begin
			kind = TYPE_ENDPOINT;
			len = ($urandom_range(4) != 0) ? 7 : $urandom_range(2, 10);
		end else if (pick < 90) begin
			kind = ($urandom_range(1) != 0) ? TYPE_HID : 8'($urandom_range(255));
			len = $urandom_range(2, 20);
		end else if (pick < 94) begin
			kind = 8'd0;
			len = 1;
		end else if (pick < 96) begin
			// zero length halts the walk; trailing bytes must be ignored
			kind = 8'd0;
			len = 0;
		end else if (pick == 96) begin
			kind = ($urandom_range(1) != 0) ? TYPE_INTERFACE : TYPE_ENDPOINT;
			len = $urandom_range(20, 255);
		end else begin
			kind = 8'd0;
			len = -1;
		end
		if (len == 0) begin
			block_bytes.push_back(8'd0);
			repeat ($urandom_range(3)) block_bytes.push_back(8'($urandom_range(255)));
		end else if (len == 1) begin
			block_bytes.push_back(8'd1);
		end else if (len < 0) begin
			repeat ($urandom_range(1, 4)) block_bytes.push_back(8'($urandom_range(255)));
		end else begin
			block_bytes.push_back(8'(len));
			block_bytes.push_back(kind);
			for (int i = 2; i < len; i++) begin
				if (kind == TYPE_ENDPOINT && i == 2)
					block_bytes.push_back(addr);
				else if (kind == TYPE_ENDPOINT && i == 3)
					block_bytes.push_back(attr);
				else if (kind == TYPE_ENDPOINT && i == 4)
					block_bytes.push_back(mp[7:0]);
				else if (kind == TYPE_ENDPOINT && i == 5)
					block_bytes.push_back(mp[15:8]);
				else
					block_bytes.push_back(8'($urandom_range(255)));
			end
		end
	endtask

	task automatic run_random_blocks(input int budget);
		int start;
		int cut;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			block_bytes.delete();
			if ($urandom_range(9) != 0) begin
				block_bytes.push_back(8'd9);
				block_bytes.push_back(TYPE_CONFIGURATION);
				repeat (7) block_bytes.push_back(8'($urandom_range(255)));
			end
			repeat ($urandom_range(1, 6)) push_descriptor();
			if ($urandom_range(9) == 0) begin
				cut = $urandom_range(1, block_bytes.size());
				while (block_bytes.size() > cut) void'(block_bytes.pop_back());
			end
			send_block();
		end
	endtask

	task automatic test_directed_walk();
		// full interface, IN and OUT interrupt endpoints at the extremes, then a halt
		block_bytes = {8'h08, TYPE_INTERFACE, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
			8'h06, TYPE_ENDPOINT, 8'h8F, 8'hFF, 8'hFF, 8'hFF,
			8'h06, TYPE_ENDPOINT, 8'h0F, 8'h03, 8'h00, 8'h00,
			8'h00, 8'hAA};
		send_block();
		// length-one skip, then an interface cut short by the end
		block_bytes = {8'h01, 8'h05, TYPE_INTERFACE, 8'hFF};
		send_block();
		// endpoint too short to hold its fields, then a new descriptor cut short
		block_bytes = {8'h05, TYPE_ENDPOINT, 8'h81, 8'h03, 8'hFF, 8'h09};
		send_block();
	endtask

	task automatic test_endpoint_type_sweep();
		write_endpoint_type(XFER_CONTROL);
		run_random_blocks(310);
		write_endpoint_type(XFER_BULK);
		run_random_blocks(310);
		write_endpoint_type(XFER_ISOCH);
		run_random_blocks(310);
		write_endpoint_type(XFER_INTERRUPT);
		run_random_blocks(310);
	endtask

	task automatic test_steady_stream();
		write_endpoint_type(XFER_BULK);
		sender_idles = 1'b0;
		recv_idles = 1'b0;
		run_random_blocks(300);
		sender_idles = 1'b1;
		recv_idles = 1'b1;
	endtask

	task automatic test_result_backpressure();
		settle();
		sender_idles = 1'b0;
		hold_span = 80;
		@(posedge clk);
		repeat (24) begin
			block_bytes = {8'($urandom_range(255)), 8'($urandom_range(255))};
			send_block();
		end
		sender_idles = 1'b1;
		settle();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		wanted_endpoint_type <= XFER_INTERRUPT;
		in_valid <= 1'b0;
		data_byte <= 8'd0;
		last_byte <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_walk();
		test_endpoint_type_sweep();
		test_steady_stream();
		test_result_backpressure();
		settle();
		$display("walked %0d bytes in %0d blocks, %0d reports checked, %0d mismatches",
			bytes_sent, blocks_sent, reports_checked, mismatches);
		$display("all four endpoint types, halts, skips, cut and oversized descriptors, held sink");
		if (mismatches == 0 && expected_reports.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
